// File: src/tspk_pkg.sv
// Package for the transport stream packetizer: the command passed from the
// front part to the back part, packet constants and the header byte function.
// Depends on nothing.
`timescale 1ns / 1ps

package tspk_pkg;

	localparam logic [7:0] SYNC_BYTE    = 8'h47;
	localparam logic [7:0] PAYLOAD_MAX  = 8'd184;
	localparam logic [7:0] PACKET_BYTES = 8'd188;
	localparam logic [7:0] PTR_COST     = 8'd1;
	localparam logic [7:0] PCR_COST     = 8'd8;
	localparam logic [7:0] STUFF_BYTE   = 8'hFF;
	localparam logic [7:0] PCR_FLAGS    = 8'h10;
	localparam logic [7:0] PCR_AF_LEN   = 8'd7;
	localparam logic [6:0] PCR_RSV      = 7'h7E;
	localparam logic [3:0] AFC_BOTH     = 4'h3;
	localparam logic [3:0] AFC_PAYLOAD  = 4'h1;
	localparam logic [7:0] AF_END_PCR   = 8'd12;
	localparam logic [7:0] AF_END_PLAIN = 8'd4;
	localparam int         FIFO_DEPTH   = 4;

	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_DATA  = 1'b1;

	typedef enum logic {
		PH_HEAD,
		PH_DATA
	} phase_t;

	// One queued item of work: an optional packet header, then an optional byte.
	typedef struct packed {
		logic        do_hdr;
		logic        first;
		logic        ptr;
		logic [7:0]  ptrv;
		logic        pcr;
		logic [32:0] base;
		logic [7:0]  pad;
		logic [3:0]  cc;
		logic [12:0] pid;
		logic        do_byte;
		logic [7:0]  data;
		logic        pend;
		logic        uend;
	} cmd_t;

	// Total header length: fixed part, adaptation field with stuffing, pointer.
	function automatic logic [7:0] hdr_len(cmd_t c);
		logic [7:0] len;
		len = (c.pcr ? AF_END_PCR : AF_END_PLAIN) + c.pad + {7'd0, c.ptr};
		return len;
	endfunction

	function automatic logic [7:0] hdr_byte(cmd_t c, logic [7:0] i);
		logic [7:0] afend;
		logic [7:0] b;
		afend = (c.pcr ? AF_END_PCR : AF_END_PLAIN) + c.pad;
		if (i == 8'd0) begin
			b = SYNC_BYTE;
		end else if (i == 8'd1) begin
			b = {1'b0, c.first, 1'b0, c.pid[12:8]};
		end else if (i == 8'd2) begin
			b = c.pid[7:0];
		end else if (i == 8'd3) begin
			b = {((c.pad != 8'd0) || c.pcr) ? AFC_BOTH : AFC_PAYLOAD, c.cc};
		end else if (i >= afend) begin
			b = c.ptrv;
		end else if (c.pcr) begin
			case (i)
				8'd4:    b = PCR_AF_LEN + c.pad;
				8'd5:    b = PCR_FLAGS;
				8'd6:    b = c.base[32:25];
				8'd7:    b = c.base[24:17];
				8'd8:    b = c.base[16:9];
				8'd9:    b = c.base[8:1];
				8'd10:   b = {c.base[0], PCR_RSV};
				8'd11:   b = 8'h00;
				default: b = STUFF_BYTE;
			endcase
		end else begin
			case (i)
				8'd4:    b = c.pad - 8'd1;
				8'd5:    b = 8'h00;
				default: b = STUFF_BYTE;
			endcase
		end
		return b;
	endfunction

endpackage

// File: src/ts_payload_packetizer.sv
// Top level of the transport stream packetizer: joins the front part, the
// command queue and the back part. Uses tspk_pkg, tspk_front, tspk_fifo, tspk_back.
`timescale 1ns / 1ps

// The block cuts payload units into 188-byte transport packets and delivers
// them as big-endian 32-bit words, packet_end on the 47th word of each packet
// and unit_end on the last word of a unit. A start item (func 0) opens a unit
// and produces the first packet header with its optional PCR adaptation field,
// stuffing and pointer byte; data items (func 1) add one payload byte each,
// and a data item that opens a new packet also produces that packet's header.
// The front end accepts one item per cycle while the four-entry command queue
// has room. The back end works on one queued item at a time: an item without
// a header passes the empty header phase, then its byte is taken and the item
// popped in the data phase. An item that produces a header first packs out
// the header, hlen bytes (up to 188 for a zero-length unit), one 32-bit word
// per cycle while the output register is free; the bytes of a last partial
// word go to the word buffer. A finished word waits in the output register
// while out_stall holds. The queue lets up to four items be taken while a
// header drains; a single output register holds the last word while the back
// end keeps packing bytes that do not complete a word.
// One continuity counter is kept per slot; STREAMS sets how many exist,
// at most sixteen, and slots at or above STREAMS fold onto slot modulo STREAMS.
module ts_payload_packetizer #(
	parameter int STREAMS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [3:0]  stream_slot,
	input  logic [12:0] pid,
	input  logic [15:0] unit_length,
	input  logic        has_pointer,
	input  logic [7:0]  pointer_value,
	input  logic        has_pcr,
	input  logic [32:0] pcr_base,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] ts_word,
	output logic        packet_end,
	output logic        unit_end
);

	logic           full;
	logic           accept;
	logic           push;
	logic           pop;
	logic           not_empty;
	tspk_pkg::cmd_t wr_cmd;
	tspk_pkg::cmd_t rd_cmd;

	// The front end works only while the queue can take a command.
	assign in_stall = full;
	assign accept   = in_valid && !full;

	tspk_front #(.STREAMS(STREAMS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.func          (func),
		.stream_slot   (stream_slot),
		.pid           (pid),
		.unit_length   (unit_length),
		.has_pointer   (has_pointer),
		.pointer_value (pointer_value),
		.has_pcr       (has_pcr),
		.pcr_base      (pcr_base),
		.data_byte     (data_byte),
		.push          (push),
		.cmd           (wr_cmd)
	);

	tspk_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_cmd    (wr_cmd),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.rd_cmd    (rd_cmd)
	);

	tspk_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (not_empty),
		.cmd        (rd_cmd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.ts_word    (ts_word),
		.packet_end (packet_end),
		.unit_end   (unit_end)
	);

	// A unit always ends exactly where a packet ends, since the last packet
	// is stuffed to fit the remaining payload.
	a_unit_end_at_packet_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && unit_end) |-> packet_end)
		else $error("unit end flagged away from a packet end");

endmodule

// File: src/tspk_front.sv
// Front part of the packetizer: accepts items, tracks unit and packet
// progress and continuity counters, and queues work commands. Uses tspk_pkg.
`timescale 1ns / 1ps

module tspk_front #(
	parameter int STREAMS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic               func,
	input  logic [3:0]         stream_slot,
	input  logic [12:0]        pid,
	input  logic [15:0]        unit_length,
	input  logic               has_pointer,
	input  logic [7:0]         pointer_value,
	input  logic               has_pcr,
	input  logic [32:0]        pcr_base,
	input  logic [7:0]         data_byte,
	output logic               push,
	output tspk_pkg::cmd_t     cmd
);

	// Slots are four bits wide, so at most sixteen counters are reachable.
	localparam int CC_DEPTH = (STREAMS < 16) ? STREAMS : 16;
	localparam int IDX_W    = (CC_DEPTH > 1) ? $clog2(CC_DEPTH) : 1;

	logic [3:0]  cc_q [CC_DEPTH];
	logic [15:0] ubl_q;
	logic [7:0]  psl_q;
	logic [12:0] pid_q;
	logic [3:0]  slot_q;
	logic        active_q;

	logic [3:0]       slot_sel;
	logic [IDX_W-1:0] idx;
	logic [3:0]       cc_next;
	logic             cc_wr;
	logic [7:0]       space;
	logic [7:0]       take;
	logic [7:0]       psl_cur;
	logic [15:0]      ubl_dec;
	logic [7:0]       psl_dec;

	always_comb begin
		slot_sel = (func == tspk_pkg::FUNC_START) ? stream_slot : slot_q;
		// Slots fold onto the counters through a small constant table.
		idx = '0;
		for (int k = 0; k < 16; k++) begin
			if (slot_sel == 4'(k)) idx = IDX_W'(k % CC_DEPTH);
		end
		cc_next  = cc_q[idx] + 4'd1;
		if (func == tspk_pkg::FUNC_START) begin
			space = tspk_pkg::PAYLOAD_MAX - (has_pointer ? tspk_pkg::PTR_COST : 8'd0)
				- (has_pcr ? tspk_pkg::PCR_COST : 8'd0);
			take  = (unit_length < {8'd0, space}) ? unit_length[7:0] : space;
		end else begin
			space = tspk_pkg::PAYLOAD_MAX;
			take  = (ubl_q < {8'd0, space}) ? ubl_q[7:0] : space;
		end
		psl_cur = (psl_q == 8'd0) ? take : psl_q;
		psl_dec = psl_cur - 8'd1;
		ubl_dec = ubl_q - 16'd1;

		cmd         = '0;
		cmd.ptrv    = pointer_value;
		cmd.base    = pcr_base;
		cmd.cc      = cc_next;
		cmd.pad     = space - take;
		cmd.data    = data_byte;
		cmd.pend    = (psl_dec == 8'd0);
		cmd.uend    = (ubl_dec == 16'd0);
		push        = 1'b0;
		cc_wr       = 1'b0;
		if (accept) begin
			if (func == tspk_pkg::FUNC_START) begin
				push        = 1'b1;
				cc_wr       = 1'b1;
				cmd.do_hdr  = 1'b1;
				cmd.first   = 1'b1;
				cmd.ptr     = has_pointer;
				cmd.pcr     = has_pcr;
				cmd.pid     = pid;
			end else if (active_q && ubl_q != 16'd0) begin
				push        = 1'b1;
				cc_wr       = (psl_q == 8'd0);
				cmd.do_hdr  = (psl_q == 8'd0);
				cmd.pid     = pid_q;
				cmd.do_byte = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < CC_DEPTH; k++) cc_q[k] <= 4'd0;
			ubl_q    <= 16'd0;
			psl_q    <= 8'd0;
			pid_q    <= 13'd0;
			slot_q   <= 4'd0;
			active_q <= 1'b0;
		end else if (accept) begin
			if (cc_wr) cc_q[idx] <= cc_next;
			if (func == tspk_pkg::FUNC_START) begin
				ubl_q    <= unit_length;
				psl_q    <= take;
				pid_q    <= pid;
				slot_q   <= stream_slot;
				active_q <= (unit_length != 16'd0);
			end else if (push) begin
				ubl_q    <= ubl_dec;
				psl_q    <= psl_dec;
				active_q <= (ubl_dec != 16'd0);
			end else begin
				active_q <= 1'b0;
			end
		end
	end

endmodule

// File: src/tspk_fifo.sv
// Short command queue between the front and back parts of the packetizer.
// Uses tspk_pkg for the command type and depth.
`timescale 1ns / 1ps

module tspk_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tspk_pkg::cmd_t wr_cmd,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output tspk_pkg::cmd_t rd_cmd
);

	localparam int AW = $clog2(tspk_pkg::FIFO_DEPTH);

	tspk_pkg::cmd_t mem_q [tspk_pkg::FIFO_DEPTH];
	logic [AW-1:0]  wr_q;
	logic [AW-1:0]  rd_q;
	logic [AW:0]    cnt_q;

	assign full      = (cnt_q == (AW+1)'(tspk_pkg::FIFO_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign rd_cmd    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wr_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("command queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("command queue underflow");

endmodule

// File: src/tspk_back.sv
// Back part of the packetizer: expands queued commands into header bytes and
// payload bytes and packs them into 32-bit output words. Uses tspk_pkg.
`timescale 1ns / 1ps

module tspk_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  tspk_pkg::cmd_t cmd,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [31:0]    ts_word,
	output logic           packet_end,
	output logic           unit_end
);

	tspk_pkg::phase_t phase_q, phase_d;
	logic [7:0]  pos_q, pos_d;
	logic [23:0] buf_q, buf_d;
	logic [1:0]  fill_q, fill_d;
	logic        ov_q;
	logic [31:0] word_q;
	logic        pend_q, uend_q;

	logic        out_free;
	logic        emit;
	logic [31:0] emit_word;
	logic        emit_pend, emit_uend;
	logic [7:0]  hlen;
	logic [7:0]  rem;
	logic [7:0]  b0, b1, b2, b3;

	assign out_free = !ov_q || !out_stall;

	always_comb begin
		hlen = tspk_pkg::hdr_len(cmd);
		rem  = hlen - pos_q;
		b0   = tspk_pkg::hdr_byte(cmd, pos_q);
		b1   = tspk_pkg::hdr_byte(cmd, pos_q + 8'd1);
		b2   = tspk_pkg::hdr_byte(cmd, pos_q + 8'd2);
		b3   = tspk_pkg::hdr_byte(cmd, pos_q + 8'd3);

		phase_d   = phase_q;
		pos_d     = pos_q;
		buf_d     = buf_q;
		fill_d    = fill_q;
		pop       = 1'b0;
		emit      = 1'b0;
		emit_word = {b0, b1, b2, b3};
		emit_pend = 1'b0;
		emit_uend = 1'b0;

		if (cmd_valid) begin
			unique case (phase_q)
				tspk_pkg::PH_HEAD: begin
					if (cmd.do_hdr) begin
						// Headers always begin on a word boundary.
						if (rem >= 8'd4) begin
							if (out_free) begin
								emit      = 1'b1;
								emit_pend = (rem == 8'd4) && (hlen == tspk_pkg::PACKET_BYTES);
								emit_uend = emit_pend;
								pos_d     = pos_q + 8'd4;
								if (rem == 8'd4) begin
									fill_d  = 2'd0;
									phase_d = tspk_pkg::PH_DATA;
								end
							end
						end else begin
							fill_d  = rem[1:0];
							case (rem[1:0])
								2'd1:    buf_d = {16'd0, b0};
								2'd2:    buf_d = {8'd0, b0, b1};
								default: buf_d = {b0, b1, b2};
							endcase
							phase_d = tspk_pkg::PH_DATA;
						end
					end else begin
						phase_d = tspk_pkg::PH_DATA;
					end
				end
				tspk_pkg::PH_DATA: begin
					if (!cmd.do_byte) begin
						pop = 1'b1;
					end else if (fill_q == 2'd3) begin
						if (out_free) begin
							emit      = 1'b1;
							emit_word = {buf_q, cmd.data};
							emit_pend = cmd.pend;
							emit_uend = cmd.uend;
							fill_d    = 2'd0;
							pop       = 1'b1;
						end
					end else begin
						buf_d  = {buf_q[15:0], cmd.data};
						fill_d = fill_q + 2'd1;
						pop    = 1'b1;
					end
					if (pop) begin
						phase_d = tspk_pkg::PH_HEAD;
						pos_d   = 8'd0;
					end
				end
				default: phase_d = tspk_pkg::PH_HEAD;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tspk_pkg::PH_HEAD;
			pos_q   <= 8'd0;
			fill_q  <= 2'd0;
			ov_q    <= 1'b0;
		end else begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			fill_q  <= fill_d;
			if (emit) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		buf_q <= buf_d;
		if (emit) begin
			word_q <= emit_word;
			pend_q <= emit_pend;
			uend_q <= emit_uend;
		end
	end

	assign out_valid  = ov_q;
	assign ts_word    = word_q;
	assign packet_end = pend_q;
	assign unit_end   = uend_q;

	a_pos_in_header: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd.do_hdr && phase_q == tspk_pkg::PH_HEAD) |-> (pos_q < hlen))
		else $error("header position beyond header length");
	a_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> out_free)
		else $error("word written into an occupied output register");

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for ts_payload_packetizer: drives start and payload byte
// items, predicts the packet words and compares every output word field by field.
// Depends on tspk_pkg and the ts_payload_packetizer RTL.
`timescale 1ns / 1ps

module testbench;

	// One input item as it goes to the ports.
	typedef struct {
		logic        func;
		logic [3:0]  slot;
		logic [12:0] pid;
		logic [15:0] len;
		logic        ptr;
		logic [7:0]  ptrv;
		logic        pcr;
		logic [32:0] base;
		logic [7:0]  data;
	} ts_item_t;

	// One expected packet word.
	typedef struct {
		logic [31:0] word;
		logic        pend;
		logic        uend;
	} ts_word_t;

	// A directed row; when has_words is set, the typed-in words are also checked
	// against the predictor output so the table doubles as a sanity check of it.
	typedef struct {
		ts_item_t    item;
		bit          has_words;
		int          nwords;
		logic [31:0] w0;
		logic [31:0] wlast;
	} dir_row_t;

	localparam int CYCLE_LIMIT = 2000000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        func;
	logic [3:0]  stream_slot;
	logic [12:0] pid;
	logic [15:0] unit_length;
	logic        has_pointer;
	logic [7:0]  pointer_value;
	logic        has_pcr;
	logic [32:0] pcr_base;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] ts_word;
	logic        packet_end;
	logic        unit_end;

	ts_payload_packetizer dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .stream_slot(stream_slot), .pid(pid),
		.unit_length(unit_length), .has_pointer(has_pointer),
		.pointer_value(pointer_value), .has_pcr(has_pcr), .pcr_base(pcr_base),
		.data_byte(data_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.ts_word(ts_word), .packet_end(packet_end), .unit_end(unit_end)
	);

	// Predictor state, mirroring what the block keeps between items.
	logic [3:0]  cc_table [16];
	logic [15:0] bytes_left;
	logic [7:0]  space_left;
	logic [23:0] pend_bytes;
	logic [1:0]  pend_fill;
	logic [12:0] cur_pid;
	logic [3:0]  cur_slot;
	logic        active;

	ts_word_t    words_due[$];
	// Every predicted word since the last clear, kept for the directed table; never popped.
	ts_word_t    words_log[$];
	int          errors;
	int          words_seen;
	int          units_sent;
	longint      cycles;
	int          send_idle_pct;
	int          recv_stall_pct;

	// Items from the stimulus process waiting to be driven.
	ts_item_t    tx_queue[$];

	always #1 clk = ~clk;

	// Packs one byte into the word assembler and queues a full word.
	task automatic pack_byte(input logic [7:0] b, input logic pe, input logic ue);
		ts_word_t w;
		if (pend_fill == 2'd3) begin
			w.word = {pend_bytes, b};
			w.pend = pe;
			w.uend = ue;
			words_due.push_back(w);
			words_log.push_back(w);
			pend_bytes = '0;
			pend_fill  = 2'd0;
		end else begin
			pend_bytes = {pend_bytes[15:0], b};
			pend_fill  = pend_fill + 2'd1;
		end
	endtask

	// Steps the slot counter and emits a packet header with the given stuffing.
	task automatic emit_packet_header(input logic first, input logic ptr,
			input logic [7:0] ptrv, input logic pcr, input logic [32:0] base,
			input int pad);
		logic [7:0] hb[$];
		logic [3:0] cc;
		int         i;
		cc = cc_table[cur_slot] + 4'd1;
		cc_table[cur_slot] = cc;
		hb.push_back(8'h47);
		hb.push_back({1'b0, first, 1'b0, cur_pid[12:8]});
		hb.push_back(cur_pid[7:0]);
		if (pcr) begin
			hb.push_back({4'h3, cc});
			hb.push_back(8'(7 + pad));
			hb.push_back(8'h10);
			hb.push_back(base[32:25]);
			hb.push_back(base[24:17]);
			hb.push_back(base[16:9]);
			hb.push_back(base[8:1]);
			hb.push_back({base[0], 7'h7E});
			hb.push_back(8'h00);
			for (i = 0; i < pad; i++) hb.push_back(8'hFF);
		end else if (pad == 1) begin
			hb.push_back({4'h3, cc});
			hb.push_back(8'h00);
		end else if (pad > 1) begin
			hb.push_back({4'h3, cc});
			hb.push_back(8'(pad - 1));
			hb.push_back(8'h00);
			for (i = 0; i + 2 < pad; i++) hb.push_back(8'hFF);
		end else begin
			hb.push_back({4'h1, cc});
		end
		if (ptr) hb.push_back(ptrv);
		// Only a header that fills the whole packet (zero-length unit) ends it.
		for (i = 0; i < hb.size(); i++)
			pack_byte(hb[i], hb.size() == 188 && i == hb.size() - 1,
				hb.size() == 188 && i == hb.size() - 1);
	endtask

	// Works out the words that one accepted item produces.
	task automatic predict_packet_words(input ts_item_t it);
		int room;
		int take;
		if (it.func == tspk_pkg::FUNC_START) begin
			cur_slot   = it.slot;
			cur_pid    = it.pid;
			bytes_left = it.len;
			pend_bytes = '0;
			pend_fill  = '0;
			room = 184 - (it.ptr ? 1 : 0) - (it.pcr ? 8 : 0);
			take = (it.len < room) ? it.len : room;
			emit_packet_header(1'b1, it.ptr, it.ptrv, it.pcr, it.base, room - take);
			space_left = 8'(take);
			active = (it.len != 0);
		end else if (!active || bytes_left == 0) begin
			active = 1'b0;
		end else begin
			if (space_left == 0) begin
				take = (bytes_left < 184) ? bytes_left : 184;
				emit_packet_header(1'b0, 1'b0, 8'h00, 1'b0, 33'd0, 184 - take);
				space_left = 8'(take);
			end
			space_left = space_left - 8'd1;
			bytes_left = bytes_left - 16'd1;
			pack_byte(it.data, space_left == 0, bytes_left == 0);
			if (bytes_left == 0) active = 1'b0;
		end
	endtask

	function automatic ts_item_t start_item(input logic [3:0] s, input logic [12:0] p,
			input logic [15:0] n, input logic pt, input logic [7:0] pv,
			input logic pc, input logic [32:0] b);
		ts_item_t it;
		it.func = tspk_pkg::FUNC_START; it.slot = s; it.pid = p; it.len = n;
		it.ptr = pt; it.ptrv = pv; it.pcr = pc; it.base = b;
		it.data = 8'($urandom);
		return it;
	endfunction

	function automatic ts_item_t byte_item(input logic [7:0] d);
		ts_item_t it;
		it.func = tspk_pkg::FUNC_DATA; it.data = d;
		// Start fields are don't-care on a byte item, so they carry noise.
		it.slot = 4'($urandom); it.pid = 13'($urandom); it.len = 16'($urandom);
		it.ptr = 1'($urandom); it.ptrv = 8'($urandom); it.pcr = 1'($urandom);
		it.base = 33'({$urandom, $urandom});
		return it;
	endfunction

	function automatic ts_item_t rand_start(input int maxlen);
		return start_item(4'($urandom), 13'($urandom), 16'($urandom_range(0, maxlen)),
			1'($urandom), 8'($urandom), 1'($urandom), 33'({$urandom, $urandom}));
	endfunction

	// Sender: the only process that drives the input port. It puts an item on
	// the ports, holds it until accepted, and inserts random idle cycles.
	initial begin
		ts_item_t it;
		in_valid = 1'b0;
		func = 1'b0; stream_slot = '0; pid = '0; unit_length = '0;
		has_pointer = 1'b0; pointer_value = '0; has_pcr = 1'b0;
		pcr_base = '0; data_byte = '0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (in_valid && !in_stall) begin
				predict_packet_words(tx_queue.pop_front());
			end
			if (tx_queue.size() != 0 &&
					($urandom_range(0, 99) >= send_idle_pct ||
					(in_valid && in_stall))) begin
				it = tx_queue[0];
				in_valid      <= 1'b1;
				func          <= it.func;
				stream_slot   <= it.slot;
				pid           <= it.pid;
				unit_length   <= it.len;
				has_pointer   <= it.ptr;
				pointer_value <= it.ptrv;
				has_pcr       <= it.pcr;
				pcr_base      <= it.base;
				data_byte     <= it.data;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stall and the word check at each accepted output.
	initial begin
		ts_word_t w;
		out_stall = 1'b1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				words_seen++;
				if (words_due.size() == 0) begin
					$error("word %h arrived with nothing expected", ts_word);
					errors++;
				end else begin
					w = words_due.pop_front();
					if (ts_word !== w.word) begin
						$error("ts_word: expected %h, got %h", w.word, ts_word);
						errors++;
					end
					if (packet_end !== w.pend) begin
						$error("packet_end: expected %b, got %b", w.pend, packet_end);
						errors++;
					end
					if (unit_end !== w.uend) begin
						$error("unit_end: expected %b, got %b", w.uend, unit_end);
						errors++;
					end
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Watchdog on total run length.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// Waits until every queued item has been taken by the block.
	task automatic drain_items();
		while (tx_queue.size() != 0 || in_valid) @(posedge clk);
	endtask

	// Queues a start item followed by the given number of random byte items.
	task automatic queue_unit(input ts_item_t s, input int nbytes);
		int i;
		tx_queue.push_back(s);
		units_sent++;
		for (i = 0; i < nbytes; i++) tx_queue.push_back(byte_item(8'($urandom)));
	endtask

	initial begin
		dir_row_t   rows[$];
		dir_row_t   r;
		int         i;
		int         k;
		int         nb;
		int         phase;
		ts_item_t   s;
		clk = 1'b0;
		arst_n = 1'b0;
		errors = 0;
		words_seen = 0;
		units_sent = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		active = 1'b0; bytes_left = '0; space_left = '0;
		pend_bytes = '0; pend_fill = '0; cur_pid = '0; cur_slot = '0;
		for (i = 0; i < 16; i++) cc_table[i] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table. Rows with typed words give the first and last word of
		// what that item produces; the rest are checked only by the predictor.
		// A zero-length unit right after reset: one stuffed packet, cc 1.
		rows.push_back('{start_item(4'd0, 13'd0, 16'd0, 1'b0, 8'd0, 1'b0, 33'd0),
			1'b1, 47, 32'h47400031, 32'hFFFFFFFF});
		// Same with the largest PID and slot, and a PCR: the PCR field stretches.
		rows.push_back('{start_item(4'd15, 13'h1FFF, 16'd0, 1'b0, 8'd0, 1'b1,
			33'h1FFFFFFFF), 1'b1, 47, 32'h475FFF31, 32'hFFFFFFFF});
		// Full first packet: a plain four-byte header word with unit start.
		rows.push_back('{start_item(4'd3, 13'h0ABC, 16'd184, 1'b0, 8'd0, 1'b0, 33'd0),
			1'b1, 1, 32'h474ABC11, 32'h474ABC11});
		for (k = 0; k < 6; k++) rows.push_back('{byte_item(8'(k)), 0, 0, 0, 0});
		// Abandoned unit; a one-byte stuffing case (182 with a pointer) follows.
		rows.push_back('{start_item(4'd3, 13'd5, 16'd183, 1'b0, 8'd0, 1'b0, 33'd0),
			0, 0, 0, 0});
		rows.push_back('{start_item(4'd1, 13'd5, 16'd182, 1'b1, 8'hFF, 1'b0, 33'd0),
			0, 0, 0, 0});
		// Two-byte stuffing, then a single-byte unit with everything set.
		rows.push_back('{start_item(4'd2, 13'd7, 16'd182, 1'b0, 8'd0, 1'b0, 33'd0),
			0, 0, 0, 0});
		rows.push_back('{start_item(4'd4, 13'd7, 16'd1, 1'b1, 8'h00, 1'b1, 33'd1),
			0, 0, 0, 0});
		rows.push_back('{byte_item(8'hFF), 0, 0, 0, 0});
		// Extra bytes after the unit is done produce nothing.
		rows.push_back('{byte_item(8'h00), 0, 0, 0, 0});
		rows.push_back('{byte_item(8'hA5), 0, 0, 0, 0});
		for (i = 0; i < rows.size(); i++) begin
			r = rows[i];
			words_log.delete();
			tx_queue.push_back(r.item);
			drain_items();
			if (r.has_words) begin
				if (words_log.size() != r.nwords ||
						words_log[0].word !== r.w0 ||
						words_log[words_log.size() - 1].word !== r.wlast) begin
					$error("directed row %0d: predicted words differ from table", i);
					errors++;
				end
			end
		end

		// Random part in idling phases. Most units are well formed with short
		// lengths; a few are long, cut short or overrun by extra bytes. Each
		// phase sends about 48 items, and a unit that would run past that is cut.
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
				default: begin send_idle_pct = 32; recv_stall_pct = 32; end
			endcase
			k = 0;
			while (k < 48) begin
				s = rand_start(($urandom_range(0, 9) == 0) ? 400 : 30);
				nb = int'(s.len);
				if ($urandom_range(0, 5) == 0) nb = int'($urandom_range(0, nb));
				else if ($urandom_range(0, 5) == 0) nb = nb + int'($urandom_range(1, 3));
				if (nb > 48 - k) nb = 48 - k;
				queue_unit(s, nb);
				k += nb + 1;
				drain_items();
			end
			// Hold off new input until the output side has caught up.
			while (words_due.size() != 0) @(posedge clk);
		end
		recv_stall_pct = 0;
		while (words_due.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("Covered %0d units and %0d checked words over four idling phases,",
			units_sent, words_seen);
		$display("including zero-length, PCR, pointer, stuffing, abandon and overrun.");
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
